@@ hdl/amx_pkg.sv @@
// Shared types, constants and the knee table generator of the audio mix accumulator.
`timescale 1ns / 1ps

package amx_pkg;

   localparam int DEF_BUF_DEPTH      = 4096;
   localparam int DEF_KNEE_LUT_DEPTH = 256;

   localparam int SAMPLE_W     = 16;
   localparam int STORE_W      = 20;
   localparam int ADDR_W       = 17;
   localparam int FRAC_W       = 15;
   localparam int Y_W          = 31;
   localparam int LIMIT_STAGES = 5;
   localparam int STEP_W       = 3;

   localparam logic MODE_ACCUMULATE = 1'b0;
   localparam logic MODE_DRAIN      = 1'b1;

   localparam logic signed [STORE_W-1:0] STORE_MAX = 20'sh7FFFF;
   localparam logic signed [STORE_W-1:0] STORE_MIN = 20'sh80000;

   localparam logic [STORE_W-1:0] KNEE_POINT = 20'd26214;
   localparam logic [15:0]        KNEE_SPAN  = 16'd6554;
   localparam logic [14:0]        FULL_SCALE = 15'd32767;
   localparam logic [Y_W-1:0]     KNEE_BASE  = 31'd858980352;
   localparam logic [45:0]        Q30_HALF   = 46'd536870912;
   localparam logic [30:0]        Q15_HALF   = 31'd16384;
   localparam logic [63:0]        Q30_ONE    = 64'd1073741824;

   typedef struct packed {
      logic                       mode;
      logic [11:0]                write_offset;
      logic [3:0]                 dest_stride;
      logic [11:0]                sample_number;
      logic signed [SAMPLE_W-1:0] sample_value;
   } amx_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       last;
      logic                       empty_res;
   } amx_rsp_type;

   typedef struct packed {
      logic clear;
      logic load_req;
      logic acc_check;
      logic acc_write;
      logic drain_check;
      logic load_rsp;
   } amx_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic acc_ok;
      logic buf_empty;
      logic rsp_free;
   } amx_status_type;

   // Restoring long division, evaluated only while the design elaborates.
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Entry index of the tanh knee table: round(32768*tanh(5*index/depth)), at most 32767.
   function automatic logic [15:0] knee_entry(int unsigned index, int unsigned depth);
      logic [63:0] z;
      logic [63:0] term;
      logic [63:0] r;
      logic [63:0] p;
      logic [63:0] den;
      logic [63:0] t;
      z    = udiv64(64'd10 * Q30_ONE, 64'(depth));
      term = Q30_ONE;
      r    = Q30_ONE;
      p    = Q30_ONE;
      for (int unsigned k = 1; k <= 30; k++) begin
         term = udiv64((term * z) >> 30, 64'(k));
         if (k[0]) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      for (int unsigned i = 0; i < index; i++) begin
         p = (p * r + (Q30_ONE >> 1)) >> 30;
      end
      den = Q30_ONE + p;
      t   = udiv64(((Q30_ONE - p) << 15) + (den >> 1), den);
      if (t > 64'd32767) begin
         t = 64'd32767;
      end
      return t[15:0];
   endfunction

endpackage

@@ hdl/amx_controller.sv @@
// Sequencing state machine of the audio mix accumulator.
`timescale 1ns / 1ps

module amx_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   input  amx_pkg::amx_status_type status,
   output amx_pkg::amx_cmd_type    cmd,
   output logic                    req_stall
);
   import amx_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC_CHECK,
      ST_ACC_WRITE,
      ST_DRN_CHECK,
      ST_LIMIT,
      ST_DRN_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode == MODE_DRAIN) ? ST_DRN_CHECK : ST_ACC_CHECK;
            end
         end
         ST_ACC_CHECK: begin
            state_in = status.acc_ok ? ST_ACC_WRITE : ST_IDLE;
         end
         ST_ACC_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_DRN_CHECK: begin
            step_in  = '0;
            state_in = status.buf_empty ? ST_DRN_OUT : ST_LIMIT;
         end
         ST_LIMIT: begin
            if (step_ff == STEP_W'(LIMIT_STAGES - 1)) begin
               state_in = ST_DRN_OUT;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DRN_OUT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      cmd.clear       = (state_ff == ST_CLEAR);
      cmd.load_req    = (state_ff == ST_IDLE) && req_valid;
      cmd.acc_check   = (state_ff == ST_ACC_CHECK);
      cmd.acc_write   = (state_ff == ST_ACC_WRITE);
      cmd.drain_check = (state_ff == ST_DRN_CHECK);
      cmd.load_rsp    = (state_ff == ST_DRN_OUT) && status.rsp_free;
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_write_after_check: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_write |-> $past(status.acc_ok))
      else $error("Accumulate write without an in-range address.");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRN_OUT |->
         ($past(state_ff) == ST_LIMIT || $past(state_ff) == ST_DRN_CHECK ||
          $past(state_ff) == ST_DRN_OUT))
      else $error("Result stage entered from an unexpected state.");

   a_limit_latency: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRN_OUT && $past(state_ff) == ST_LIMIT) |->
         $past(step_ff) == STEP_W'(LIMIT_STAGES - 1))
      else $error("Limiter left before all stages had settled.");

endmodule

@@ hdl/amx_datapath.sv @@
// Mix store, fill and drain counters, soft limiter pipeline and result register.
`timescale 1ns / 1ps

module amx_datapath #(
   parameter int BUF_DEPTH      = amx_pkg::DEF_BUF_DEPTH,
   parameter int KNEE_LUT_DEPTH = amx_pkg::DEF_KNEE_LUT_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  amx_pkg::amx_req_type    req_data,
   input  amx_pkg::amx_cmd_type    cmd,
   input  logic                    rsp_stall,
   output amx_pkg::amx_status_type status,
   output logic                    rsp_valid,
   output amx_pkg::amx_rsp_type    rsp_data
);
   import amx_pkg::*;

   localparam int IDX_W = $clog2(BUF_DEPTH);
   localparam int CNT_W = $clog2(BUF_DEPTH + 1);
   localparam int LUT_W = $clog2(KNEE_LUT_DEPTH);
   localparam int X_W   = STORE_W + $clog2(KNEE_LUT_DEPTH + 1);
   localparam int XI_W  = X_W - FRAC_W;

   logic [15:0] knee_rom [KNEE_LUT_DEPTH];

   for (genvar g = 0; g < KNEE_LUT_DEPTH; g++) begin : g_knee
      localparam logic [15:0] KneeValue = knee_entry(g, KNEE_LUT_DEPTH);
      assign knee_rom[g] = KneeValue;
   end

   logic signed [STORE_W-1:0] mix_store [BUF_DEPTH];
   logic signed [STORE_W-1:0] mem_rd_ff;
   logic                      mem_we;
   logic                      mem_re;
   logic [IDX_W-1:0]          mem_waddr;
   logic [IDX_W-1:0]          mem_raddr;
   logic signed [STORE_W-1:0] mem_wdata;

   amx_req_type      req_ff, req_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] drain_ff, drain_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             last_ff, last_in;
   logic             empty_ff, empty_in;
   logic             rsp_valid_ff, rsp_valid_in;
   amx_rsp_type      rsp_ff, rsp_in;

   logic [ADDR_W-1:0]         addr;
   logic                      acc_ok;
   logic                      buf_empty;
   logic signed [STORE_W:0]   sum;
   logic signed [STORE_W-1:0] sat;
   logic [CNT_W-1:0]          drain_next;
   logic [CNT_W-1:0]          fill_reach;

   // Limiter pipeline registers.
   logic                neg1_ff, neg1_in;
   logic                lin1_ff, lin1_in;
   logic [14:0]         mag1_ff, mag1_in;
   logic [X_W-1:0]      x1_ff, x1_in;
   logic [15:0]         lin2_ff, lin2_in;
   logic [15:0]         a2_ff, a2_in;
   logic [15:0]         dmag2_ff, dmag2_in;
   logic                dneg2_ff, dneg2_in;
   logic [FRAC_W-1:0]   frac2_ff, frac2_in;
   logic [30:0]         prod3_ff, prod3_in;
   logic [15:0]         a3_ff, a3_in;
   logic                dneg3_ff, dneg3_in;
   logic [Y_W-1:0]      y4_ff, y4_in;
   logic [15:0]         k5_ff, k5_in;

   logic [STORE_W-1:0] mag;
   logic [XI_W-1:0]    idx;
   logic               flat;
   logic [LUT_W-1:0]   ia;
   logic [LUT_W-1:0]   ib;
   logic [15:0]        ta;
   logic [15:0]        tb;
   logic [15:0]        t4;
   logic [45:0]        knee_prod;
   logic [15:0]        mag_out;

   assign addr = ADDR_W'(req_ff.write_offset)
               + ADDR_W'(req_ff.sample_number) * ADDR_W'(req_ff.dest_stride);
   assign acc_ok    = (addr < ADDR_W'(BUF_DEPTH)) && (addr >= ADDR_W'(drain_ff));
   assign buf_empty = (drain_ff >= fill_ff);

   assign sum = (STORE_W + 1)'(mem_rd_ff) + (STORE_W + 1)'(req_ff.sample_value);
   always_comb begin
      if (sum > (STORE_W + 1)'(STORE_MAX)) begin
         sat = STORE_MAX;
      end else if (sum < (STORE_W + 1)'(STORE_MIN)) begin
         sat = STORE_MIN;
      end else begin
         sat = sum[STORE_W-1:0];
      end
   end

   assign drain_next = drain_ff + CNT_W'(1);
   assign fill_reach = CNT_W'(addr_ff) + CNT_W'(1);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
      end else if (cmd.drain_check && !buf_empty) begin
         mem_we    = 1'b1;
         mem_waddr = drain_ff[IDX_W-1:0];
      end else if (cmd.acc_write) begin
         mem_we    = 1'b1;
         mem_wdata = sat;
      end
      mem_re    = (cmd.acc_check && acc_ok) || (cmd.drain_check && !buf_empty);
      mem_raddr = cmd.acc_check ? addr[IDX_W-1:0] : drain_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mix_store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= mix_store[mem_raddr];
      end
   end

   always_comb begin
      req_in       = cmd.load_req ? req_data : req_ff;
      clr_in       = cmd.clear ? clr_ff + IDX_W'(1) : clr_ff;
      addr_in      = cmd.acc_check ? addr[IDX_W-1:0] : addr_ff;
      fill_in      = fill_ff;
      drain_in     = drain_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      if (cmd.acc_write && (fill_reach > fill_ff)) begin
         fill_in = fill_reach;
      end
      if (cmd.drain_check) begin
         empty_in = buf_empty;
         last_in  = 1'b0;
         if (!buf_empty) begin
            if (drain_next >= fill_ff) begin
               last_in  = 1'b1;
               drain_in = '0;
               fill_in  = '0;
            end else begin
               drain_in = drain_next;
            end
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Soft limiter, one register after each arithmetic step.
   always_comb begin
      mag      = mem_rd_ff[STORE_W-1] ? (~mem_rd_ff + STORE_W'(1)) : mem_rd_ff;
      neg1_in  = mem_rd_ff[STORE_W-1];
      lin1_in  = (mag <= KNEE_POINT);
      mag1_in  = mag[14:0];
      x1_in    = X_W'(mag - KNEE_POINT) * X_W'(KNEE_LUT_DEPTH);

      idx      = x1_ff[X_W-1:FRAC_W];
      flat     = (idx >= XI_W'(KNEE_LUT_DEPTH - 1));
      ia       = flat ? LUT_W'(KNEE_LUT_DEPTH - 1) : idx[LUT_W-1:0];
      ib       = flat ? ia : ia + LUT_W'(1);
      ta       = knee_rom[ia];
      tb       = knee_rom[ib];
      a2_in    = ta;
      dneg2_in = (tb < ta);
      dmag2_in = (tb < ta) ? ta - tb : tb - ta;
      frac2_in = x1_ff[FRAC_W-1:0];
      lin2_in  = 16'((31'(mag1_ff) * 31'(FULL_SCALE) + Q15_HALF) >> FRAC_W);

      prod3_in = 31'(dmag2_ff) * 31'(frac2_ff);
      a3_in    = a2_ff;
      dneg3_in = dneg2_ff;

      t4       = dneg3_ff ? a3_ff - prod3_ff[30:FRAC_W] : a3_ff + prod3_ff[30:FRAC_W];
      y4_in    = KNEE_BASE + Y_W'(KNEE_SPAN) * Y_W'(t4);

      knee_prod = 46'(y4_ff) * 46'(FULL_SCALE) + Q30_HALF;
      k5_in     = knee_prod[45:30];
   end

   assign mag_out = lin1_ff ? lin2_ff : k5_ff;

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         if (empty_ff) begin
            rsp_in.out_sample = '0;
            rsp_in.last       = 1'b0;
            rsp_in.empty_res  = 1'b1;
         end else begin
            rsp_in.out_sample = neg1_ff ? SAMPLE_W'(16'd0 - mag_out) : mag_out;
            rsp_in.last       = last_ff;
            rsp_in.empty_res  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         fill_ff      <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      addr_ff  <= addr_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
      rsp_ff   <= rsp_in;
      neg1_ff  <= neg1_in;
      lin1_ff  <= lin1_in;
      mag1_ff  <= mag1_in;
      x1_ff    <= x1_in;
      lin2_ff  <= lin2_in;
      a2_ff    <= a2_in;
      dmag2_ff <= dmag2_in;
      dneg2_ff <= dneg2_in;
      frac2_ff <= frac2_in;
      prod3_ff <= prod3_in;
      a3_ff    <= a3_in;
      dneg3_ff <= dneg3_in;
      y4_ff    <= y4_in;
      k5_ff    <= k5_in;
   end

   always_comb begin
      status.clear_done = (clr_ff == IDX_W'(BUF_DEPTH - 1));
      status.acc_ok     = acc_ok;
      status.buf_empty  = buf_empty;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_counter_order: assert property (@(posedge clock) disable iff (reset)
      (drain_ff <= fill_ff) && (fill_ff <= CNT_W'(BUF_DEPTH)))
      else $error("Drain position or fill length out of order.");

   a_fill_covers_write: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_write |=> (CNT_W'($past(addr_ff)) < fill_ff))
      else $error("Fill length does not cover the accumulated entry.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("Result register not marked full after a load.");

endmodule

@@ hdl/audio_mix_accumulator_soft_clip_core.sv @@
// Audio mix accumulator: a mix buffer of saturating Q4.15 entries with a tanh soft limiter on
// drain. Each request is handled on its own: an accumulate request passes through accept,
// address and memory read, and saturating write back, which is skipped when its address
// is dropped; a drain request passes through accept, read and clear of the entry, five
// limiter stages and result load, which waits while the previous result is not yet taken;
// a drain of an empty buffer has neither the read and clear nor the limiter stages. These
// steps follow from the single read and write port of the mix store and from the
// five-stage limiter pipeline. After reset a clearing pass writes zero to every one of the
// BUF_DEPTH entries (4096 by default), one per cycle, and req_stall stays high throughout.
`timescale 1ns / 1ps

module audio_mix_accumulator_soft_clip_core #(
   parameter int BUF_DEPTH      = amx_pkg::DEF_BUF_DEPTH,
   parameter int KNEE_LUT_DEPTH = amx_pkg::DEF_KNEE_LUT_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  amx_pkg::amx_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output amx_pkg::amx_rsp_type rsp_data
);
   import amx_pkg::*;

   amx_cmd_type    cmd;
   amx_status_type status;

   amx_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   amx_datapath #(
      .BUF_DEPTH      (BUF_DEPTH),
      .KNEE_LUT_DEPTH (KNEE_LUT_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
